@@ hw/rtl/tipf_pkg.sv @@
// tipf_pkg: shared types and constants for the TCP ingress packet filter.
// Used by tipf_regs, tipf_check and the top level; no dependencies.
`timescale 1ns / 1ps

package tipf_pkg;

  localparam int unsigned TicksPerWindowDefault = 1000;

  localparam int unsigned CfgAddrWidth  = 4;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned SynLimitWidth = 17;
  localparam int unsigned MssWidth      = 14;
  localparam int unsigned TicksWidth    = 32;

  localparam logic [SynLimitWidth-1:0] SynCountMax = '1;

  localparam logic [4:0] TcpBaseHdrBytes = 5'd20;
  localparam logic [3:0] TcpMinDoff      = 4'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegHardening  = 2'd0;
  localparam logic [1:0] RegResetGuard = 2'd1;
  localparam logic [1:0] RegSynLimit   = 2'd2;
  localparam logic [1:0] RegMssClamp   = 2'd3;

  // flag bit positions
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagPsh = 3;
  localparam int unsigned FlagAck = 4;
  localparam int unsigned FlagUrg = 5;

  // conntrack codes
  localparam logic [2:0] CtUntracked   = 3'd1;
  localparam logic [2:0] CtEstablished = 3'd2;
  localparam logic [2:0] CtEstReply    = 3'd3;

  // drop reasons
  localparam logic [2:0] ReasonPass      = 3'd0;
  localparam logic [2:0] ReasonMalformed = 3'd1;
  localparam logic [2:0] ReasonBadFlags  = 3'd2;
  localparam logic [2:0] ReasonUntracked = 3'd3;
  localparam logic [2:0] ReasonSynRate   = 3'd4;
  localparam logic [2:0] ReasonRstGuard  = 3'd5;

  typedef struct packed {
    logic                     hardening_enable;
    logic                     reset_guard_enable;
    logic [SynLimitWidth-1:0] syn_limit;
    logic [MssWidth-1:0]      mss_clamp_value;
  } cfg_t;

  typedef struct packed {
    logic                  is_tcp;
    logic                  outbound;
    logic [15:0]           tcp_offset;
    logic [15:0]           packet_length;
    logic [3:0]            data_offset;
    logic [7:0]            tcp_flags;
    logic [2:0]            conntrack_state;
    logic [TicksWidth-1:0] now_ticks;
    logic                  tunnel_egress;
  } item_t;

endpackage

@@ hw/rtl/tcp_ingress_packet_filter_core.sv @@
// tcp_ingress_packet_filter_core: top level of the TCP ingress packet filter.
// Depends on tipf_pkg, tipf_regs and tipf_check.
`timescale 1ns / 1ps

// One header summary in, one verdict (drop, drop_reason, clamp_mss) out, one
// request per clock sustained. out_valid rises once the accepted request has moved on
// from the input register: the request is registered, the checks and the SYN window
// update run in one combinational pass, and the verdict lands in the result
// register. The input takes a new request while a verdict waits, and stalls only
// when both the input stage and the result register are full and out_stall is high.
// Configuration is to be written through the APB port only while the filter is
// idle (not enforced). TICKS_PER_WINDOW sets the SYN rate window length in ticks.
module tcp_ingress_packet_filter_core #(
  parameter int unsigned TICKS_PER_WINDOW = tipf_pkg::TicksPerWindowDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tipf_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [tipf_pkg::CfgDataWidth-1:0] pwdata,
  output logic [tipf_pkg::CfgDataWidth-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              is_tcp,
  input  logic                              outbound,
  input  logic [15:0]                       tcp_offset,
  input  logic [15:0]                       packet_length,
  input  logic [3:0]                        data_offset,
  input  logic [7:0]                        tcp_flags,
  input  logic [2:0]                        conntrack_state,
  input  logic [tipf_pkg::TicksWidth-1:0]   now_ticks,
  input  logic                              tunnel_egress,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              drop,
  output logic [2:0]                        drop_reason,
  output logic                              clamp_mss
);

  tipf_pkg::cfg_t  cfg;
  tipf_pkg::item_t in_item;

  assign in_item = '{
    is_tcp:          is_tcp,
    outbound:        outbound,
    tcp_offset:      tcp_offset,
    packet_length:   packet_length,
    data_offset:     data_offset,
    tcp_flags:       tcp_flags,
    conntrack_state: conntrack_state,
    now_ticks:       now_ticks,
    tunnel_egress:   tunnel_egress
  };

  tipf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tipf_check #(
    .TICKS_PER_WINDOW (TICKS_PER_WINDOW)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drop        (drop),
    .drop_reason (drop_reason),
    .clamp_mss   (clamp_mss)
  );

endmodule

@@ hw/rtl/tipf_regs.sv @@
// tipf_regs: APB-style configuration registers for the packet filter.
// Depends on tipf_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module tipf_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tipf_pkg::CfgAddrWidth-1:0]    paddr,
  input  logic [tipf_pkg::CfgDataWidth-1:0]    pwdata,
  output logic [tipf_pkg::CfgDataWidth-1:0]    prdata,
  output logic                                 pready,
  output tipf_pkg::cfg_t                       cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        tipf_pkg::RegHardening:  cfg.hardening_enable   <= pwdata[0];
        tipf_pkg::RegResetGuard: cfg.reset_guard_enable <= pwdata[0];
        tipf_pkg::RegSynLimit:
          cfg.syn_limit <= pwdata[tipf_pkg::SynLimitWidth-1:0];
        tipf_pkg::RegMssClamp:
          cfg.mss_clamp_value <= pwdata[tipf_pkg::MssWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tipf_pkg::RegHardening:
        prdata = {{(tipf_pkg::CfgDataWidth-1){1'b0}}, cfg.hardening_enable};
      tipf_pkg::RegResetGuard:
        prdata = {{(tipf_pkg::CfgDataWidth-1){1'b0}}, cfg.reset_guard_enable};
      tipf_pkg::RegSynLimit:
        prdata = {{(tipf_pkg::CfgDataWidth-tipf_pkg::SynLimitWidth){1'b0}},
                  cfg.syn_limit};
      tipf_pkg::RegMssClamp:
        prdata = {{(tipf_pkg::CfgDataWidth-tipf_pkg::MssWidth){1'b0}},
                  cfg.mss_clamp_value};
      default: prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/tipf_check.sv @@
// tipf_check: input register, verdict logic with SYN rate window, result register.
// Depends on tipf_pkg for the item/cfg types, flag positions and reason codes.
`timescale 1ns / 1ps

module tipf_check #(
  parameter int unsigned TICKS_PER_WINDOW = tipf_pkg::TicksPerWindowDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  tipf_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  tipf_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           drop,
  output logic [2:0]     drop_reason,
  output logic           clamp_mss
);

  localparam logic [tipf_pkg::TicksWidth-1:0] WindowTicks =
    tipf_pkg::TicksWidth'(TICKS_PER_WINDOW);

  logic            s1_valid;
  tipf_pkg::item_t s1;
  logic            advance;
  logic            in_take;

  logic [tipf_pkg::TicksWidth-1:0]    window_start, window_start_next;
  logic [tipf_pkg::SynLimitWidth-1:0] syn_count, syn_count_next;

  logic [16:0] base_end, hdr_end;
  logic        too_short, malformed, inbound, bad_flags;
  logic        fin, syn, rst_f, ack;
  logic        rate_path, expire, est;
  logic [tipf_pkg::TicksWidth-1:0]    diff;
  logic [tipf_pkg::SynLimitWidth-1:0] cnt_base;
  logic [2:0]  reason;
  logic        clamp;

  // result register drains or is empty
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    fin   = s1.tcp_flags[tipf_pkg::FlagFin];
    syn   = s1.tcp_flags[tipf_pkg::FlagSyn];
    rst_f = s1.tcp_flags[tipf_pkg::FlagRst];
    ack   = s1.tcp_flags[tipf_pkg::FlagAck];
    inbound = !s1.outbound;

    base_end  = {1'b0, s1.tcp_offset} + {12'd0, tipf_pkg::TcpBaseHdrBytes};
    hdr_end   = {1'b0, s1.tcp_offset} + {11'd0, s1.data_offset, 2'b00};
    too_short = !s1.is_tcp || (base_end > {1'b0, s1.packet_length});
    malformed = (s1.data_offset < tipf_pkg::TcpMinDoff) ||
                (hdr_end > {1'b0, s1.packet_length});

    bad_flags = (syn && fin) || (syn && rst_f) || (fin && rst_f) ||
                (s1.tcp_flags[tipf_pkg::FlagUrg:tipf_pkg::FlagFin] == 6'd0);

    est = (s1.conntrack_state == tipf_pkg::CtEstablished) ||
          (s1.conntrack_state == tipf_pkg::CtEstReply);

    // new window when now is strictly after start + window (signed sense)
    diff   = s1.now_ticks - window_start - WindowTicks;
    expire = (diff != '0) && !diff[tipf_pkg::TicksWidth-1];

    window_start_next = window_start;
    syn_count_next    = syn_count;
    cnt_base          = expire ? '0 : syn_count;
    rate_path         = 1'b0;
    reason            = tipf_pkg::ReasonPass;
    clamp             = 1'b0;

    if (too_short) begin
      reason = tipf_pkg::ReasonPass;
    end else if (malformed) begin
      reason = cfg.hardening_enable ? tipf_pkg::ReasonMalformed : tipf_pkg::ReasonPass;
    end else begin
      if (inbound && cfg.hardening_enable && bad_flags) begin
        reason = tipf_pkg::ReasonBadFlags;
      end else if (inbound && cfg.hardening_enable &&
                   s1.conntrack_state == tipf_pkg::CtUntracked) begin
        reason = tipf_pkg::ReasonUntracked;
      end else begin
        rate_path = inbound && syn && !ack && (cfg.syn_limit != '0);
        if (rate_path) begin
          if (expire) begin
            window_start_next = s1.now_ticks;
          end
          syn_count_next = (cnt_base == tipf_pkg::SynCountMax) ? cnt_base
                                                              : cnt_base + 1'b1;
          if (syn_count_next > cfg.syn_limit) begin
            reason = tipf_pkg::ReasonSynRate;
          end
        end
        if (reason == tipf_pkg::ReasonPass && inbound && rst_f &&
            cfg.reset_guard_enable && !est) begin
          reason = tipf_pkg::ReasonRstGuard;
        end
      end
      clamp = (reason == tipf_pkg::ReasonPass) && s1.outbound &&
              (cfg.mss_clamp_value != '0) && syn && s1.tunnel_egress;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      window_start <= '0;
      syn_count    <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && advance) begin
        window_start <= window_start_next;
        syn_count    <= syn_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1 <= in_item;
    end
    if (s1_valid && advance) begin
      drop        <= (reason != tipf_pkg::ReasonPass);
      drop_reason <= reason;
      clamp_mss   <= clamp;
    end
  end

`ifndef SYNTHESIS
  a_pass_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drop |-> drop_reason == tipf_pkg::ReasonPass)
    else $error("pass verdict carries a drop reason");

  a_drop_noclamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && drop |-> !clamp_mss)
    else $error("dropped request flagged for MSS clamp");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance) |=> $stable(syn_count) && $stable(window_start))
    else $error("rate state changed without a request moving");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while a stage is free");
`endif

endmodule
